// File: rtl/core/bsfb_pkg.sv
// bsfb_pkg: shared types and constants of the byte stuffing frame builder
// no dependencies; used by every module under rtl/core
package bsfb_pkg;

	localparam int MAX_RUN   = 9;
	localparam int RUN_CNT_W = $clog2(MAX_RUN + 1);
	localparam int HDR_LEN   = 4;
	localparam int CFG_IDX_W = 2;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_FLAG   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASK   = 2'd2;

	localparam logic [7:0] FLAG_RESET   = 8'h7E;
	localparam logic [7:0] ESCAPE_RESET = 8'h7D;
	localparam logic [7:0] MASK_RESET   = 8'h20;

	typedef struct packed {
		logic [7:0] payload_byte;
		logic       first_of_packet;
		logic       last_of_packet;
		logic [7:0] frame_address;
		logic [7:0] frame_control;
	} in_item_t;

	typedef struct packed {
		logic [7:0] line_byte;
		logic       last_of_run;
		logic       frame_end;
	} out_item_t;

	typedef struct packed {
		logic [7:0] flag_byte;
		logic [7:0] escape_byte;
		logic [7:0] stuff_mask;
	} cfg_t;

	// all line bytes caused by one item, slot 0 goes out first
	typedef struct packed {
		logic [MAX_RUN-1:0][7:0]  bytes;
		logic [RUN_CNT_W-1:0]     count;
		logic                     closes;
	} run_t;

endpackage

// File: rtl/core/bsfb_run_build.sv
// bsfb_run_build: expands one registered input item into its run of line bytes
// and keeps the running xor check; depends on bsfb_pkg
module bsfb_run_build (
	input  logic                clk,
	input  logic                arst_n,
	input  bsfb_pkg::cfg_t      cfg,
	input  bsfb_pkg::in_item_t  item_s1,
	input  logic                move,
	output bsfb_pkg::run_t      run
);

	logic [7:0]                     check_q;
	logic [7:0]                     chk;
	logic                           dstuff;
	logic                           cstuff;
	logic [bsfb_pkg::RUN_CNT_W-1:0] off0;
	logic [bsfb_pkg::RUN_CNT_W-1:0] off1;
	logic [bsfb_pkg::RUN_CNT_W-1:0] off2;

	always_comb begin
		chk    = item_s1.first_of_packet ? item_s1.payload_byte
		                                 : (check_q ^ item_s1.payload_byte);
		dstuff = (item_s1.payload_byte == cfg.flag_byte) ||
		         (item_s1.payload_byte == cfg.escape_byte);
		cstuff = (chk == cfg.flag_byte) || (chk == cfg.escape_byte);
		off0   = item_s1.first_of_packet ? bsfb_pkg::RUN_CNT_W'(bsfb_pkg::HDR_LEN) : '0;
		off1   = off0 + (dstuff ? bsfb_pkg::RUN_CNT_W'(2) : bsfb_pkg::RUN_CNT_W'(1));
		off2   = off1 + (cstuff ? bsfb_pkg::RUN_CNT_W'(2) : bsfb_pkg::RUN_CNT_W'(1));
	end

	always_comb begin
		run.closes = item_s1.last_of_packet;
		run.count  = item_s1.last_of_packet ? (off2 + bsfb_pkg::RUN_CNT_W'(1)) : off1;
		for (int i = 0; i < bsfb_pkg::MAX_RUN; i++) begin
			run.bytes[i] = '0;
			if (item_s1.first_of_packet && i == 0)
				run.bytes[i] = cfg.flag_byte;
			if (item_s1.first_of_packet && i == 1)
				run.bytes[i] = item_s1.frame_address;
			if (item_s1.first_of_packet && i == 2)
				run.bytes[i] = item_s1.frame_control;
			if (item_s1.first_of_packet && i == 3)
				run.bytes[i] = item_s1.frame_address ^ item_s1.frame_control;
			if (bsfb_pkg::RUN_CNT_W'(i) == off0)
				run.bytes[i] = dstuff ? cfg.escape_byte : item_s1.payload_byte;
			if (dstuff && bsfb_pkg::RUN_CNT_W'(i) == off0 + bsfb_pkg::RUN_CNT_W'(1))
				run.bytes[i] = item_s1.payload_byte ^ cfg.stuff_mask;
			if (item_s1.last_of_packet && bsfb_pkg::RUN_CNT_W'(i) == off1)
				run.bytes[i] = cstuff ? cfg.escape_byte : chk;
			if (item_s1.last_of_packet && cstuff &&
			    bsfb_pkg::RUN_CNT_W'(i) == off1 + bsfb_pkg::RUN_CNT_W'(1))
				run.bytes[i] = chk ^ cfg.stuff_mask;
			if (item_s1.last_of_packet && bsfb_pkg::RUN_CNT_W'(i) == off2)
				run.bytes[i] = cfg.flag_byte;
		end
	end

	// check restarts on a first byte and clears after the closing flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			check_q <= '0;
		end else if (move) begin
			check_q <= item_s1.last_of_packet ? 8'h00 : chk;
		end
	end

endmodule

// File: rtl/core/bsfb_serializer.sv
// bsfb_serializer: holds one run and sends it out a byte per cycle through
// the result register while the receiver is ready; depends on bsfb_pkg
module bsfb_serializer (
	input  logic                clk,
	input  logic                arst_n,
	input  bsfb_pkg::run_t      run,
	input  logic                run_valid,
	output logic                take,
	output logic                result_valid,
	input  logic                result_ready,
	output bsfb_pkg::out_item_t result
);

	bsfb_pkg::run_t                 run_s2;
	logic                           valid_s2;
	logic [bsfb_pkg::RUN_CNT_W-1:0] idx_q;
	logic                           out_valid_q;
	bsfb_pkg::out_item_t            out_q;
	logic                           load_out;
	logic                           at_end;

	always_comb begin
		load_out = valid_s2 && (!out_valid_q || result_ready);
		at_end   = (idx_q == run_s2.count - bsfb_pkg::RUN_CNT_W'(1));
		take     = !valid_s2 || (load_out && at_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2    <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				valid_s2 <= run_valid;
				idx_q    <= '0;
			end else if (load_out) begin
				idx_q <= idx_q + bsfb_pkg::RUN_CNT_W'(1);
			end
			if (load_out)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && run_valid)
			run_s2 <= run;
		if (load_out) begin
			out_q.line_byte   <= run_s2.bytes[idx_q];
			out_q.last_of_run <= at_end;
			out_q.frame_end   <= at_end && run_s2.closes;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

// File: rtl/core/byte_stuffing_frame_builder_unit.sv
// byte_stuffing_frame_builder_unit: top level of the hdlc style frame encoder
// depends on bsfb_pkg, bsfb_run_build and bsfb_serializer
//
// Takes one payload byte per item and turns it into 1 to 9 line bytes: a first
// byte opens the frame with flag, address, control and header check; every
// payload byte that equals the flag or escape value goes out as escape plus the
// byte xor the stuff mask; a last byte adds the stuffed running xor check and
// a closing flag. Output runs one line byte per cycle unless stalled, so an
// item holds the line for its line bytes: 1 for a plain byte, 2 for a stuffed
// one, up to 9 for a one byte packet. The serializer sets the rate. Items
// enter an input register, are expanded into a full run in one pass and move
// into the serializer while the prior run is still being sent, so without
// stalls plain bytes flow at one item per cycle with no bubbles. Configuration
// writes are taken at any time but are meant only for an idle block.
module byte_stuffing_frame_builder_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                item_valid,
	output logic                                item_ready,
	input  bsfb_pkg::in_item_t                  item,
	output logic                                result_valid,
	input  logic                                result_ready,
	output bsfb_pkg::out_item_t                 result,
	input  logic                                cfg_we,
	input  logic [bsfb_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [7:0]                          cfg_data
);

	bsfb_pkg::cfg_t     cfg_q;
	bsfb_pkg::in_item_t item_s1;
	logic               valid_s1;
	bsfb_pkg::run_t     run;
	logic               run_take;

	// configuration registers, plain write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.flag_byte   <= bsfb_pkg::FLAG_RESET;
			cfg_q.escape_byte <= bsfb_pkg::ESCAPE_RESET;
			cfg_q.stuff_mask  <= bsfb_pkg::MASK_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bsfb_pkg::REG_FLAG:   cfg_q.flag_byte   <= cfg_data;
				bsfb_pkg::REG_ESCAPE: cfg_q.escape_byte <= cfg_data;
				bsfb_pkg::REG_MASK:   cfg_q.stuff_mask  <= cfg_data;
				default: ;
			endcase
		end
	end

	// input register; frees up as soon as its run moves into the serializer
	assign item_ready = !valid_s1 || run_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_ready) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_ready && item_valid)
			item_s1 <= item;
	end

	// run expansion and running check
	bsfb_run_build u_build (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.item_s1 (item_s1),
		.move    (valid_s1 && run_take),
		.run     (run)
	);

	// byte per cycle output with result register, while the receiver is ready
	bsfb_serializer u_ser (
		.clk          (clk),
		.arst_n       (arst_n),
		.run          (run),
		.run_valid    (valid_s1),
		.take         (run_take),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// a closing flag is always the last byte of its run
	a_end_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.frame_end |-> result.last_of_run)
		else $error("closing flag not at end of run");

	// a full input register that is not draining blocks new items
	a_ready_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!item_ready |-> valid_s1 && !run_take)
		else $error("input stalled without reason");

	// an accepted item reaches the input register on the next edge
	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> valid_s1)
		else $error("accepted item lost");

	// a run that moves on always has at least one byte
	a_run_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> run.count != '0)
		else $error("empty run built");

endmodule

// File: verif/tb.sv
// tb: self-checking testbench of byte_stuffing_frame_builder_unit
// depends on bsfb_pkg and the rtl/core sources; predicts every line byte locally
module tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 120;
	localparam int PHASE_ITEMS = 30;
	localparam int SETTLE      = 10;

	typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN, RX_BURSTY} rx_mode_t;

	// one directed row: n == 0 means the predictor supplies the line bytes
	typedef struct {
		bsfb_pkg::in_item_t it;
		int                 n;
		logic [0:8][7:0]    b;
	} row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           item_valid;
	logic                           item_ready;
	bsfb_pkg::in_item_t             item;
	logic                           result_valid;
	logic                           result_ready;
	bsfb_pkg::out_item_t            result;
	logic                           cfg_we;
	logic [bsfb_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [7:0]                     cfg_data;

	// typed line bytes riding along with the item currently offered
	int                   typed_cnt;
	logic [0:8][7:0]      typed_run;

	// local copy of the block: registers and running xor check
	logic [7:0]           cur_flag;
	logic [7:0]           cur_escape;
	logic [7:0]           cur_mask;
	logic [7:0]           run_xor;
	logic [0:8][7:0]      pred_run;
	int                   pred_cnt;
	bsfb_pkg::out_item_t  expected_line [$];

	// sender shaping and receiver control
	rx_mode_t             rx_mode;
	bit                   tx_steady;
	int                   burst_left;
	int                   hold_tokens;
	int                   err_count;
	int                   cycles;

	// packet generator state, mirrors the check as the items are made
	bit                   gen_open;
	int                   gen_left;
	logic [7:0]           gen_xor;

	// directed rows, typed values hold for the reset register values
	row_t dir_rows [19] = '{
		// one byte packet, everything zero
		'{'{8'h00, 1'b1, 1'b1, 8'h00, 8'h00}, 7,
			{8'h7E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7E, 8'h00, 8'h00}},
		// one byte packet of the flag value: byte and check both stuffed, nine bytes
		'{'{8'h7E, 1'b1, 1'b1, 8'hFF, 8'hFF}, 9,
			{8'h7E, 8'hFF, 8'hFF, 8'h00, 8'h7D, 8'h5E, 8'h7D, 8'h5E, 8'h7E}},
		// one byte packet of the escape value
		'{'{8'h7D, 1'b1, 1'b1, 8'hA5, 8'h5A}, 9,
			{8'h7E, 8'hA5, 8'h5A, 8'hFF, 8'h7D, 8'h5D, 8'h7D, 8'h5D, 8'h7E}},
		// open a frame, then close it with a check that equals the flag
		'{'{8'hFF, 1'b1, 1'b0, 8'h12, 8'h34}, 5,
			{8'h7E, 8'h12, 8'h34, 8'h26, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00}},
		'{'{8'h81, 1'b0, 1'b1, 8'h00, 8'h00}, 4,
			{8'h81, 8'h7D, 8'h5E, 8'h7E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
		// bytes with no frame open still go out and feed the check
		'{'{8'h7E, 1'b0, 1'b0, 8'h00, 8'h00}, 2,
			{8'h7D, 8'h5E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
		'{'{8'h00, 1'b0, 1'b1, 8'h00, 8'h00}, 4,
			{8'h00, 8'h7D, 8'h5E, 8'h7E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
		// first while a frame is open: the check restarts
		'{'{8'h01, 1'b1, 1'b0, 8'h00, 8'h00}, 5,
			{8'h7E, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00}},
		'{'{8'h02, 1'b1, 1'b0, 8'hC3, 8'h3C}, 5,
			{8'h7E, 8'hC3, 8'h3C, 8'hFF, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00}},
		'{'{8'h03, 1'b0, 1'b1, 8'h00, 8'h00}, 3,
			{8'h03, 8'h01, 8'h7E, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}},
		// longer frame with stuffed bytes in the middle, left to the predictor
		'{'{8'h20, 1'b1, 1'b0, 8'h55, 8'hAA}, 0, '0},
		'{'{8'h7D, 1'b0, 1'b0, 8'hFF, 8'hFF}, 0, '0},
		'{'{8'h7E, 1'b0, 1'b0, 8'h00, 8'hFF}, 0, '0},
		'{'{8'h5E, 1'b0, 1'b0, 8'hFF, 8'h00}, 0, '0},
		'{'{8'h00, 1'b0, 1'b1, 8'h00, 8'h00}, 0, '0},
		'{'{8'hFF, 1'b1, 1'b1, 8'hFF, 8'h00}, 0, '0},
		'{'{8'h80, 1'b1, 1'b0, 8'h0F, 8'hF0}, 0, '0},
		'{'{8'h7F, 1'b0, 1'b0, 8'h00, 8'h00}, 0, '0},
		'{'{8'h5D, 1'b0, 1'b1, 8'h00, 8'h00}, 0, '0}
	};

	byte_stuffing_frame_builder_unit i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// prediction: appends line bytes to pred_run
	function automatic void add_byte(input logic [7:0] b);
		pred_run[pred_cnt] = b;
		pred_cnt++;
	endfunction

	// flag or escape value goes out as escape plus byte xor mask
	function automatic void add_stuffed(input logic [7:0] b);
		if (b == cur_flag || b == cur_escape) begin
			add_byte(cur_escape);
			add_byte(b ^ cur_mask);
		end else begin
			add_byte(b);
		end
	endfunction

	// full run of line bytes caused by one item, updates the running check
	function automatic void build_line_run(input bsfb_pkg::in_item_t it);
		pred_cnt = 0;
		if (it.first_of_packet) begin
			add_byte(cur_flag);
			add_byte(it.frame_address);
			add_byte(it.frame_control);
			add_byte(it.frame_address ^ it.frame_control);
			run_xor = it.payload_byte;
		end else begin
			run_xor = run_xor ^ it.payload_byte;
		end
		add_stuffed(it.payload_byte);
		if (it.last_of_packet) begin
			add_stuffed(run_xor);
			add_byte(cur_flag);
			run_xor = 8'h00;
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		err_count++;
	endtask

	// payload biased toward the values that trigger stuffing
	function automatic logic [7:0] pick_payload();
		int r;
		r = $urandom_range(0, 99);
		if (r < 12)
			return cur_flag;
		else if (r < 24)
			return cur_escape;
		else if (r < 30)
			return cur_flag ^ cur_mask;
		return 8'($urandom);
	endfunction

	// mostly well-formed packets with random content, some items with free marks
	function automatic bsfb_pkg::in_item_t next_packet_byte();
		bsfb_pkg::in_item_t it;
		logic [7:0]         target;
		it.frame_address = 8'($urandom);
		it.frame_control = 8'($urandom);
		it.payload_byte  = pick_payload();
		if ($urandom_range(0, 99) < 10) begin
			it.first_of_packet = 1'($urandom);
			it.last_of_packet  = 1'($urandom);
			if (it.first_of_packet)
				gen_left = $urandom_range(1, 5);
		end else begin
			it.first_of_packet = !gen_open;
			if (it.first_of_packet)
				gen_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
					: $urandom_range(1, 5);
			it.last_of_packet = (gen_left <= 1);
		end
		// steer some closing checks onto the flag or escape value
		if (it.last_of_packet && $urandom_range(0, 3) == 0) begin
			target = $urandom_range(0, 1) ? cur_flag : cur_escape;
			it.payload_byte = (it.first_of_packet ? 8'h00 : gen_xor) ^ target;
		end
		gen_xor = it.first_of_packet ? it.payload_byte : gen_xor ^ it.payload_byte;
		if (gen_left > 0)
			gen_left--;
		if (it.last_of_packet) begin
			gen_xor  = 8'h00;
			gen_open = 1'b0;
		end else if (it.first_of_packet) begin
			gen_open = 1'b1;
		end
		return it;
	endfunction

	// called at a falling edge; returns at a falling edge after acceptance
	task automatic offer_item(input bsfb_pkg::in_item_t it, input int tcnt,
		input logic [0:8][7:0] trun);
		item       = it;
		typed_cnt  = tcnt;
		typed_run  = trun;
		item_valid = 1'b1;
		do @(posedge clk); while (!item_ready);
		@(negedge clk);
		// end of a burst: drop valid for a random gap
		if (!tx_steady && burst_left == 0) begin
			item_valid = 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(0, 10);
		end else if (burst_left > 0) begin
			burst_left--;
		end
	endtask

	// stop offering and wait until every expected line byte has come
	task automatic wait_line_empty();
		item_valid = 1'b0;
		while (expected_line.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [bsfb_pkg::CFG_IDX_W-1:0] idx,
		input logic [7:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		case (idx)
			bsfb_pkg::REG_FLAG:   cur_flag   = val;
			bsfb_pkg::REG_ESCAPE: cur_escape = val;
			bsfb_pkg::REG_MASK:   cur_mask   = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic configure(input logic [7:0] f, input logic [7:0] e, input logic [7:0] m);
		write_reg(bsfb_pkg::REG_FLAG, f);
		write_reg(bsfb_pkg::REG_ESCAPE, e);
		write_reg(bsfb_pkg::REG_MASK, m);
	endtask

	// predictor on every accepted item, checker on every accepted line byte;
	// one process so the order within an edge is fixed
	always @(posedge clk) begin : line_monitor
		bsfb_pkg::out_item_t got;
		bsfb_pkg::out_item_t want;
		if (arst_n) begin
			if (item_valid && item_ready) begin
				build_line_run(item);
				// typed rows replace the predicted bytes, the check state still advances
				if (typed_cnt != 0) begin
					pred_run = typed_run;
					pred_cnt = typed_cnt;
				end
				for (int k = 0; k < pred_cnt; k++)
					expected_line.push_back(bsfb_pkg::out_item_t'{pred_run[k],
						k == pred_cnt - 1, (k == pred_cnt - 1) && item.last_of_packet});
			end
			if (result_valid && result_ready) begin
				got = result;
				if (expected_line.size() == 0) begin
					report_mismatch("line byte with nothing expected",
						int'(got.line_byte), 0);
				end else begin
					want = expected_line.pop_front();
					if (got.line_byte !== want.line_byte)
						report_mismatch("line_byte", int'(got.line_byte),
							int'(want.line_byte));
					if (got.last_of_run !== want.last_of_run)
						report_mismatch("last_of_run", int'(got.last_of_run),
							int'(want.last_of_run));
					if (got.frame_end !== want.frame_end)
						report_mismatch("frame_end", int'(got.frame_end),
							int'(want.frame_end));
				end
			end
		end
	end

	// receiver: stall pattern per mode, plus a long hold-off on request
	initial begin : line_sink
		int hold_left;
		int hold_seen;
		int beat;
		hold_left    = 0;
		hold_seen    = 0;
		beat         = 0;
		result_ready = 1'b0;
		forever begin
			@(negedge clk);
			beat++;
			if (hold_seen != hold_tokens) begin
				hold_seen = hold_tokens;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_ready = 1'b0;
			end else begin
				case (rx_mode)
					RX_ALWAYS:  result_ready = 1'b1;
					RX_RANDOM:  result_ready = ($urandom_range(0, 99) < 60);
					RX_PATTERN: result_ready = (beat % 5 != 0) && (beat % 7 != 3);
					default:    result_ready = ((beat / 16) % 2 == 0) || ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin : stimulus
		arst_n      = 1'b0;
		item_valid  = 1'b0;
		item        = '0;
		typed_cnt   = 0;
		typed_run   = '0;
		cfg_we      = 1'b0;
		cfg_index   = bsfb_pkg::REG_FLAG;
		cfg_data    = 8'h00;
		cur_flag    = bsfb_pkg::FLAG_RESET;
		cur_escape  = bsfb_pkg::ESCAPE_RESET;
		cur_mask    = bsfb_pkg::MASK_RESET;
		run_xor     = 8'h00;
		pred_cnt    = 0;
		pred_run    = '0;
		rx_mode     = RX_ALWAYS;
		tx_steady   = 1'b0;
		burst_left  = 0;
		hold_tokens = 0;
		err_count   = 0;
		cycles      = 0;
		gen_open    = 1'b0;
		gen_left    = 0;
		gen_xor     = 8'h00;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed rows at the reset register values
		for (int i = 0; i < $size(dir_rows); i++)
			offer_item(dir_rows[i].it, dir_rows[i].n, dir_rows[i].b);
		wait_line_empty();

		// random phases, each with a register setting and a receiver pattern
		for (int p = 0; p < 6; p++) begin
			case (p)
				0: configure(8'h00, 8'hFF, 8'hFF);
				// flag equal to escape with a zero mask
				1: configure(8'h55, 8'h55, 8'h00);
				3: configure(8'hFF, 8'h00, 8'h80);
				5: configure(bsfb_pkg::FLAG_RESET, bsfb_pkg::ESCAPE_RESET,
					bsfb_pkg::MASK_RESET);
				default: configure(8'($urandom), 8'($urandom), 8'($urandom));
			endcase
			rx_mode   = rx_mode_t'(p % 4);
			tx_steady = (p == 1 || p == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// receiver holds off while items keep coming, so the block backs up
				if (p == 2 && n == 4)
					hold_tokens++;
				// sender pauses mid-phase until the line has drained
				if (p == 3 && n == 15)
					wait_line_empty();
				offer_item(next_packet_byte(), 0, '0);
			end
			wait_line_empty();
		end

		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
